### design/dll_pkg.sv
// Package for the linked list manager: sizes, operation and status codes, types.
// No dependencies.
`timescale 1ns / 1ps
package dll_pkg;
    localparam int POOL_DEPTH  = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(POOL_DEPTH + 1);
    localparam int ADDR_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W       = $clog2(POOL_DEPTH + 1);
    localparam logic [IDX_W-1:0] NIL = IDX_W'(POOL_DEPTH);

    localparam logic [2:0] K_INS_HEAD  = 3'd0;
    localparam logic [2:0] K_INS_TAIL  = 3'd1;
    localparam logic [2:0] K_INS_AFTER = 3'd2;
    localparam logic [2:0] K_DEL_HEAD  = 3'd3;
    localparam logic [2:0] K_DEL_TAIL  = 3'd4;
    localparam logic [2:0] K_DEL_KEY   = 3'd5;
    localparam logic [2:0] K_CLEAR     = 3'd6;
    localparam logic [2:0] K_DUMP      = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOKEY = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [IDX_W-1:0]       next;
        logic [IDX_W-1:0]       prev;
    } t_node;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_node             wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;
endpackage

### design/dll_node_ram.sv
// Node pool memory: one write port, one registered read port.
// Depends on dll_pkg.
`timescale 1ns / 1ps
module dll_node_ram
    import dll_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_node    o_rdata
);
    t_node r_mem [POOL_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

### design/doubly_linked_list_manager_core.sv
// Top level of the linked list manager: operation sequencer around the node pool RAM.
// Depends on dll_pkg and dll_node_ram.
`timescale 1ns / 1ps
// Usage:
//  Issue an operation by raising i_start with i_kind, i_value and i_key while o_busy
//  is low; the transaction is taken at that clock edge and o_busy rises.
//  Results come on o_status, o_data, o_last and o_count, each marked by o_valid for
//  one cycle. The receiver cannot stall; results are never held.
//  Every operation but dump gives one result with o_last set and o_count the
//  entry count afterwards. Dump gives one result per node, head to tail, the last
//  flagged; an empty dump gives one result with status list-empty.
//  A key search walks the list from the head, one node at a time; each node walked
//  takes a read state and a check state, since the node RAM read port is registered.
//  o_busy stays high through the final result cycle; the next transaction is taken
//  in the cycle after it.
//  Reset (synchronous, active low) empties the list and frees every node; the
//  node RAM contents are not cleared and need no clearing pass.
module doubly_linked_list_manager_core
    import dll_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_key,
    output logic               o_busy,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_data,
    output logic               o_last,
    output logic [4:0]         o_count
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_LNK   = 3'd3;
    localparam logic [2:0] S_FIX   = 3'd4;
    localparam logic [2:0] S_FIX2  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;
    localparam logic [2:0] S_FIX3  = 3'd7;

    logic [2:0]             r_state, n_state;
    logic [POOL_DEPTH-1:0]  r_free, n_free;
    logic [IDX_W-1:0]       r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [2:0]             r_kind, n_kind;
    logic [VALUE_WIDTH-1:0] r_val, n_val, r_key, n_key;
    logic [IDX_W-1:0]       r_ptr, n_ptr;
    logic [CNT_W-1:0]       r_steps, n_steps;
    logic [1:0]             r_st, n_st;
    t_node                  r_cur, n_cur;
    logic [IDX_W-1:0]       r_new, n_new;

    t_mem_req s_req;
    t_node    s_rdata;
    logic     s_valid, s_last;
    logic [1:0]  s_status;
    logic [31:0] s_data;

    logic [IDX_W-1:0] s_alloc;
    logic             s_full;

    dll_node_ram u_ram (.i_clk(i_clk), .i_req(s_req), .o_rdata(s_rdata));

    function automatic logic [ADDR_W-1:0] ad(input logic [IDX_W-1:0] i);
        return i[ADDR_W-1:0];
    endfunction

    function automatic logic [31:0] to_data(input logic [VALUE_WIDTH-1:0] v);
        logic signed [63:0] x;
        x = 64'(signed'(v));
        return x[31:0];
    endfunction

    always_comb begin
        s_alloc = NIL;
        for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
            if (r_free[i]) s_alloc = IDX_W'(i);
        end
        s_full = (r_free == '0);
    end

    wire s_head_ok = (r_head != NIL);
    wire s_nx_ok   = (s_rdata.next != NIL);

    always_comb begin
        n_state = r_state; n_free = r_free; n_head = r_head; n_tail = r_tail;
        n_cnt = r_cnt; n_kind = r_kind; n_val = r_val; n_key = r_key;
        n_ptr = r_ptr; n_steps = r_steps; n_st = r_st; n_cur = r_cur; n_new = r_new;
        s_req = '0;
        s_req.raddr = ad(r_ptr);
        s_valid = 1'b0; s_status = ST_OK; s_data = '0; s_last = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_start && !o_valid) begin
                    n_kind = i_kind;
                    n_val = VALUE_WIDTH'(i_value);
                    n_key = VALUE_WIDTH'(i_key);
                    n_st = ST_OK;
                    n_steps = '0;
                    n_state = S_DONE;
                    case (i_kind)
                        K_INS_HEAD, K_INS_TAIL: begin
                            if (s_full) begin
                                n_st = ST_FULL;
                            end else begin
                                n_new = s_alloc;
                                n_free[ad(s_alloc)] = 1'b0;
                                n_cnt = r_cnt + 1'b1;
                                s_req.we = 1'b1;
                                s_req.waddr = ad(s_alloc);
                                s_req.wdata.value = VALUE_WIDTH'(i_value);
                                if (!s_head_ok) begin
                                    s_req.wdata.next = NIL; s_req.wdata.prev = NIL;
                                    n_head = s_alloc; n_tail = s_alloc;
                                end else if (i_kind == K_INS_HEAD) begin
                                    s_req.wdata.next = r_head; s_req.wdata.prev = NIL;
                                    n_head = s_alloc; n_ptr = r_head;
                                    n_state = S_RD;
                                end else begin
                                    s_req.wdata.next = NIL; s_req.wdata.prev = r_tail;
                                    n_tail = s_alloc; n_ptr = r_tail;
                                    n_state = S_RD;
                                end
                            end
                        end
                        K_DEL_HEAD, K_DEL_TAIL: begin
                            if (!s_head_ok) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_ptr = (i_kind == K_DEL_HEAD) ? r_head : r_tail;
                                n_state = S_RD;
                            end
                        end
                        K_INS_AFTER, K_DEL_KEY, K_DUMP: begin
                            if (!s_head_ok) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_ptr = r_head;
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_free = '1; n_head = NIL; n_tail = NIL; n_cnt = '0;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_cur = s_rdata;
                case (r_kind)
                    K_INS_HEAD: begin
                        s_req.we = 1'b1; s_req.waddr = ad(r_ptr);
                        s_req.wdata = s_rdata; s_req.wdata.prev = r_new;
                        n_state = S_DONE;
                    end
                    K_INS_TAIL: begin
                        s_req.we = 1'b1; s_req.waddr = ad(r_ptr);
                        s_req.wdata = s_rdata; s_req.wdata.next = r_new;
                        n_state = S_DONE;
                    end
                    K_DUMP: begin
                        s_valid = 1'b1;
                        s_data = to_data(s_rdata.value);
                        s_last = !s_nx_ok || (r_steps == CNT_W'(POOL_DEPTH - 1));
                        n_steps = r_steps + 1'b1;
                        n_ptr = s_rdata.next;
                        n_state = s_last ? S_IDLE : S_RD;
                    end
                    K_DEL_HEAD, K_DEL_TAIL: begin
                        n_state = S_LNK;
                    end
                    default: begin
                        if (s_rdata.value == r_key) begin
                            if (r_kind == K_INS_AFTER && s_full) begin
                                n_st = ST_FULL; n_state = S_DONE;
                            end else begin
                                n_state = S_LNK;
                            end
                        end else if (!s_nx_ok || r_steps == CNT_W'(POOL_DEPTH - 1)) begin
                            n_st = ST_NOKEY; n_state = S_DONE;
                        end else begin
                            n_steps = r_steps + 1'b1;
                            n_ptr = s_rdata.next;
                            n_state = S_RD;
                        end
                    end
                endcase
            end
            S_LNK: begin
                if (r_kind == K_INS_AFTER) begin
                    n_new = s_alloc;
                    n_free[ad(s_alloc)] = 1'b0;
                    n_cnt = r_cnt + 1'b1;
                    s_req.we = 1'b1; s_req.waddr = ad(s_alloc);
                    s_req.wdata.value = r_val;
                    s_req.wdata.prev = r_ptr;
                    s_req.wdata.next = r_cur.next;
                    if (r_cur.next == NIL) n_tail = s_alloc;
                    n_state = S_FIX;
                end else begin
                    n_free[ad(r_ptr)] = 1'b1;
                    if (r_cnt != '0) n_cnt = r_cnt - 1'b1;
                    if (r_cur.prev == NIL) n_head = r_cur.next;
                    if (r_cur.next == NIL) n_tail = r_cur.prev;
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                if (r_kind == K_INS_AFTER) begin
                    s_req.we = 1'b1; s_req.waddr = ad(r_ptr);
                    s_req.wdata = r_cur; s_req.wdata.next = r_new;
                    s_req.raddr = ad(r_cur.next);
                    n_state = (r_cur.next != NIL) ? S_FIX3 : S_DONE;
                end else if (r_cur.prev != NIL) begin
                    s_req.raddr = ad(r_cur.prev);
                    n_state = S_FIX2;
                end else begin
                    s_req.raddr = ad(r_cur.next);
                    n_state = (r_cur.next != NIL) ? S_FIX3 : S_DONE;
                end
            end
            S_FIX2: begin
                // predecessor read issued in S_FIX is on s_rdata now
                s_req.we = 1'b1; s_req.waddr = ad(r_cur.prev);
                s_req.wdata = s_rdata; s_req.wdata.next = r_cur.next;
                s_req.raddr = ad(r_cur.next);
                n_state = (r_cur.next != NIL) ? S_FIX3 : S_DONE;
            end
            S_FIX3: begin
                // successor read is on s_rdata now
                s_req.we = 1'b1; s_req.waddr = ad(r_cur.next);
                s_req.wdata = s_rdata;
                s_req.wdata.prev = (r_kind == K_INS_AFTER) ? r_new : r_cur.prev;
                n_state = S_DONE;
            end
            default: begin
                s_valid = 1'b1; s_status = r_st; s_last = 1'b1;
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_free <= '1; r_head <= NIL; r_tail <= NIL; r_cnt <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_free <= n_free; r_head <= n_head; r_tail <= n_tail;
            r_cnt <= n_cnt;
            o_valid <= s_valid;
        end
        r_kind <= n_kind; r_val <= n_val; r_key <= n_key; r_ptr <= n_ptr;
        r_steps <= n_steps; r_st <= n_st; r_cur <= n_cur; r_new <= n_new;
        o_status <= s_status; o_data <= s_data; o_last <= s_last;
        o_count <= 5'(n_cnt);
    end

    assign o_busy = (r_state != S_IDLE) || o_valid;

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(POOL_DEPTH)) else $error("count over pool depth");
    a_empty_nil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_cnt == '0) |-> (r_head == NIL && r_tail == NIL))
        else $error("empty list with live head");
    a_free_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_free) + r_cnt == POOL_DEPTH))
        else $error("free map and count disagree");
    a_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start not taken");
`endif
endmodule

### verif/dll_checker.sv
// Checker for the linked list manager: watches accepted operations and result strobes,
// keeps its own list model and compares every result field. Depends on dll_pkg.
`timescale 1ns / 1ps
module dll_checker
    import dll_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_key,
    input  logic               i_valid,
    input  logic [1:0]         i_status,
    input  logic signed [31:0] i_data,
    input  logic               i_last,
    input  logic [4:0]         i_count,
    output int                 o_errors,
    output int                 o_pending
);
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data;
        logic        last;
        logic [4:0]  count;
    } t_result;

    t_result     exp_results[$];
    logic [31:0] list_vals[$];

    assign o_pending = exp_results.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        o_errors++;
    endtask

    function automatic int find_val(input logic [31:0] k);
        foreach (list_vals[i]) if (list_vals[i] == k) return i;
        return -1;
    endfunction

    task automatic predict_op(input logic [2:0] kind, input logic [31:0] v,
                              input logic [31:0] k);
        logic [1:0] st;
        int at;
        st = ST_OK;
        case (kind)
            K_INS_HEAD: if (list_vals.size() >= POOL_DEPTH) st = ST_FULL;
                        else list_vals.push_front(v);
            K_INS_TAIL: if (list_vals.size() >= POOL_DEPTH) st = ST_FULL;
                        else list_vals.push_back(v);
            K_INS_AFTER: begin
                at = find_val(k);
                if (list_vals.size() == 0) st = ST_EMPTY;
                else if (at < 0) st = ST_NOKEY;
                else if (list_vals.size() >= POOL_DEPTH) st = ST_FULL;
                else list_vals.insert(at + 1, v);
            end
            K_DEL_HEAD: if (list_vals.size() == 0) st = ST_EMPTY;
                        else void'(list_vals.pop_front());
            K_DEL_TAIL: if (list_vals.size() == 0) st = ST_EMPTY;
                        else void'(list_vals.pop_back());
            K_DEL_KEY: begin
                at = find_val(k);
                if (list_vals.size() == 0) st = ST_EMPTY;
                else if (at < 0) st = ST_NOKEY;
                else list_vals.delete(at);
            end
            K_CLEAR: list_vals.delete();
            default: begin
                if (list_vals.size() == 0) st = ST_EMPTY;
                else begin
                    foreach (list_vals[i])
                        exp_results.push_back({ST_OK, list_vals[i],
                            1'(i == list_vals.size() - 1), 5'(list_vals.size())});
                    return;
                end
            end
        endcase
        exp_results.push_back({st, 32'd0, 1'b1, 5'(list_vals.size())});
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            exp_results.delete();
            list_vals.delete();
        end else begin
            if (i_valid) begin
                if (exp_results.size() == 0) report_mismatch("unexpected result", 0, 0);
                else begin
                    e = exp_results.pop_front();
                    if (i_status !== e.status) report_mismatch("status", i_status, e.status);
                    if (i_data !== e.data) report_mismatch("data", i_data, e.data);
                    if (i_last !== e.last) report_mismatch("last", i_last, e.last);
                    if (i_count !== e.count) report_mismatch("count", i_count, e.count);
                end
            end
            if (i_start && !i_busy) predict_op(i_kind, i_value, i_key);
        end
    end

    initial o_errors = 0;
endmodule

### verif/doubly_linked_list_manager_core_tb.sv
// Top of the linked list manager testbench: clock, reset, directed and random operations,
// watchdog and verdict. Depends on dll_pkg, dll_checker and the core.
`timescale 1ns / 1ps
module doubly_linked_list_manager_core_tb;
    import dll_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_start = 0;
    logic [2:0]         i_kind = K_CLEAR;
    logic signed [31:0] i_value = 0;
    logic signed [31:0] i_key = 0;
    logic               o_busy, o_valid, o_last;
    logic [1:0]         o_status;
    logic signed [31:0] o_data;
    logic [4:0]         o_count;
    int                 errors, pending;
    int                 idle_cycles = 0;
    int                 idle_pct = 20;
    logic [31:0]        used_vals[$];

    always #5 i_clk = ~i_clk;

    doubly_linked_list_manager_core i_dut (.*);

    dll_checker i_chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_kind, .i_value, .i_key,
        .i_valid(o_valid), .i_status(o_status), .i_data(o_data), .i_last(o_last),
        .i_count(o_count), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // returns in the time step of the accepting edge, with i_start still high
    task automatic send_op(input logic [2:0] kind, input logic [31:0] v,
                           input logic [31:0] k);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 0;
            @(posedge i_clk);
        end
        i_start <= 1;
        i_kind  <= kind;
        i_value <= v;
        i_key   <= k;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic drain();
        i_start <= 0;
        @(posedge i_clk);
        while (pending > 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_key();
        if (used_vals.size() > 0 && $urandom_range(3) != 0)
            return used_vals[$urandom_range(used_vals.size() - 1)];
        return $urandom;
    endfunction

    task automatic random_op();
        logic [31:0] v;
        logic [2:0]  kind;
        int r;
        r = $urandom_range(99);
        v = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(7));
        if (r < 22) kind = K_INS_HEAD;
        else if (r < 44) kind = K_INS_TAIL;
        else if (r < 58) kind = K_INS_AFTER;
        else if (r < 66) kind = K_DEL_HEAD;
        else if (r < 74) kind = K_DEL_TAIL;
        else if (r < 86) kind = K_DEL_KEY;
        else if (r < 89) kind = K_CLEAR;
        else kind = K_DUMP;
        used_vals.push_back(v);
        if (used_vals.size() > 24) void'(used_vals.pop_front());
        send_op(kind, v, pick_key());
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_op(K_DUMP, 0, 0);
        send_op(K_DEL_HEAD, 0, 0);
        send_op(K_DEL_TAIL, 0, 0);
        send_op(K_DEL_KEY, 0, 5);
        send_op(K_INS_AFTER, 1, 5);
        send_op(K_CLEAR, 0, 0);
        send_op(K_INS_HEAD, 32'h8000_0000, 0);
        send_op(K_DEL_HEAD, 0, 0);
        send_op(K_INS_TAIL, 32'h7FFF_FFFF, 0);
        send_op(K_INS_AFTER, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_op(K_INS_AFTER, 3, 32'h1234);
        send_op(K_DEL_KEY, 0, 32'hFFFF_FFFF);
        send_op(K_DUMP, 0, 0);
        for (int i = 0; i < POOL_DEPTH; i++) send_op(K_INS_TAIL, 32'(i), 0);
        send_op(K_INS_HEAD, 99, 0);
        send_op(K_INS_AFTER, 99, 32'h0000_0007);
        send_op(K_INS_AFTER, 99, 32'h5555_5555);
        send_op(K_DUMP, 0, 0);
        send_op(K_DEL_TAIL, 0, 0);
        send_op(K_CLEAR, 0, 0);
        drain();
        for (int i = 0; i < 300; i++) begin
            idle_pct = (i >= 100 && i < 160) ? 0 : 20;
            if (i == 200) drain();
            random_op();
        end
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
